// File: hdl/arpl_pkg.sv
// Shared types, constants and codes for the ARP egress port lookup block.
package arpl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int PORT_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int OPCODE_W    = 16;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;

    localparam logic [OPCODE_W-1:0] OP_REQUEST = OPCODE_W'(1);
    localparam logic [OPCODE_W-1:0] OP_REPLY   = OPCODE_W'(2);

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE_ROUTE = 2'd0,
        ACT_WRITE_ORDER = 2'd1,
        ACT_LOOKUP      = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_PASS    = 2'd0,
        RES_FOUND   = 2'd1,
        RES_NO_PORT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        logic [PORT_W-1:0] port;
    } route_entry_t;

    typedef struct packed {
        logic              route_we;
        logic              order_we;
        logic [SLOT_W-1:0] wr_index;
        logic [SLOT_W-1:0] wr_target;
        logic              order_rd_en;
        logic [SLOT_W-1:0] order_rd_pos;
        logic              route_rd_en;
        logic [SLOT_W-1:0] route_rd_slot;
    } tbl_ctrl_t;

endpackage

// File: hdl/arpl_route_table.sv
// Route table and scan order memories with registered read ports.
module arpl_route_table (
    input  logic                        clk,
    input  arpl_pkg::tbl_ctrl_t         ctrl,
    input  arpl_pkg::route_entry_t      wr_entry,
    output logic [arpl_pkg::SLOT_W-1:0] order_rd_slot,
    output arpl_pkg::route_entry_t      route_rd_data
);
    import arpl_pkg::*;

    route_entry_t      route_mem [TABLE_DEPTH];
    logic [SLOT_W-1:0] order_mem [TABLE_DEPTH];

    logic [SLOT_W-1:0] order_q_reg;
    route_entry_t      route_q_reg;

    // Writes and reads never overlap: writes happen only while the block is idle.
    always_ff @(posedge clk)
    begin
        if (ctrl.route_we)
        begin
            route_mem[ctrl.wr_index] <= wr_entry;
        end
        if (ctrl.order_we)
        begin
            order_mem[ctrl.wr_index] <= ctrl.wr_target;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.order_rd_en)
        begin
            order_q_reg <= order_mem[ctrl.order_rd_pos];
        end
        if (ctrl.route_rd_en)
        begin
            route_q_reg <= route_mem[ctrl.route_rd_slot];
        end
    end

    assign order_rd_slot = order_q_reg;
    assign route_rd_data = route_q_reg;

endmodule

// File: hdl/arp_egress_port_masked_lookup.sv
// Top level of the ARP egress port lookup over a masked IPv4 route table.
//
// The block stores up to sixteen routes (address, mask, egress port) and a scan
// order list that maps scan positions to route slots; write requests fill both
// and produce no result. A lookup request returns exactly one result: status 0
// for a packet that is not ARP, status 1 with the port and route slot of the
// first route in scan order whose masked address equals the masked key (sender
// address for an ARP request, target address for an ARP reply) and whose port
// differs from the arrival port, and status 2 otherwise. The scan runs over a
// three-stage pipeline (order memory read, route memory read, masked compare)
// that starts one scan position per cycle. A miss finishes once every scan
// position below the limit has left the pipeline, a hit ends the scan at
// once, and a lookup that needs no scan (not ARP, other opcode, or a zero
// count) goes straight to the finish state and offers its result when the
// input is free again. The input is stalled while a lookup is in progress or
// its result cannot yet move into the output register; a finished result
// waits in that register while the next request is taken. entry_count values
// above sixteen scan all sixteen positions, and the register may be written
// only while the block is idle.
module arp_egress_port_masked_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    // Lookup and table write requests.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [arpl_pkg::ACTION_W-1:0] action,
    input  logic [arpl_pkg::SLOT_W-1:0]   slot,
    input  logic [arpl_pkg::ADDR_W-1:0]   route_ip,
    input  logic [arpl_pkg::ADDR_W-1:0]   route_mask,
    input  logic [arpl_pkg::PORT_W-1:0]   route_port,
    input  logic [arpl_pkg::SLOT_W-1:0]   order_target,
    input  logic                          is_arp,
    input  logic [arpl_pkg::OPCODE_W-1:0] arp_opcode,
    input  logic [arpl_pkg::ADDR_W-1:0]   sender_addr,
    input  logic [arpl_pkg::ADDR_W-1:0]   target_addr,
    input  logic [arpl_pkg::PORT_W-1:0]   arrival_port,
    // Lookup results.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [arpl_pkg::STATUS_W-1:0] status,
    output logic [arpl_pkg::PORT_W-1:0]   egress_port,
    output logic [arpl_pkg::SLOT_W-1:0]   matched_slot,
    // Scan count register write.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [arpl_pkg::COUNT_W-1:0]  entry_count
);
    import arpl_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic [ADDR_W-1:0]   key_reg, key_next;
    logic [PORT_W-1:0]   arrival_reg, arrival_next;
    logic [COUNT_W-1:0]  limit_reg, limit_next;
    logic [COUNT_W-1:0]  issue_pos_reg, issue_pos_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s2_valid_reg, s2_valid_next;
    logic [SLOT_W-1:0]   s2_slot_reg, s2_slot_next;
    status_t             res_status_reg, res_status_next;
    logic [PORT_W-1:0]   res_port_reg, res_port_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [PORT_W-1:0]   out_port_reg, out_port_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;

    logic                in_accept;
    logic                issue;
    logic                route_hit;
    logic                out_load;
    logic [COUNT_W-1:0]  count_sat;
    tbl_ctrl_t           tbl_ctrl;
    route_entry_t        wr_entry;
    logic [SLOT_W-1:0]   order_slot;
    route_entry_t        rd_entry;

    arpl_route_table u_table (
        .clk           (clk),
        .ctrl          (tbl_ctrl),
        .wr_entry      (wr_entry),
        .order_rd_slot (order_slot),
        .route_rd_data (rd_entry)
    );

    // The count register may be written at any time it is offered; the user
    // only writes it while no lookup is in flight.
    assign cfg_ready = 1'b1;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign count_sat = (entry_count_reg > DEPTH_COUNT) ? DEPTH_COUNT : entry_count_reg;

    // A scan position is started while positions remain below the limit.
    assign issue = (state_reg == S_SCAN) && (issue_pos_reg < limit_reg);

    // Masked compare and arrival port check on the entry that left the route memory this cycle.
    assign route_hit = s2_valid_reg
                    && ((key_reg & rd_entry.mask) == (rd_entry.addr & rd_entry.mask))
                    && (rd_entry.port != arrival_reg);

    assign wr_entry.addr = route_ip;
    assign wr_entry.mask = route_mask;
    assign wr_entry.port = route_port;

    always_comb
    begin
        tbl_ctrl.route_we      = in_accept && (action == ACT_WRITE_ROUTE);
        tbl_ctrl.order_we      = in_accept && (action == ACT_WRITE_ORDER);
        tbl_ctrl.wr_index      = slot;
        tbl_ctrl.wr_target     = order_target;
        tbl_ctrl.order_rd_en   = issue;
        tbl_ctrl.order_rd_pos  = issue_pos_reg[SLOT_W-1:0];
        tbl_ctrl.route_rd_en   = (state_reg == S_SCAN) && s1_valid_reg;
        tbl_ctrl.route_rd_slot = order_slot;
    end

    // Sequencer: accepts requests when idle, runs the scan pipeline, and hands
    // the finished result to the output register.
    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        arrival_next    = arrival_reg;
        limit_next      = limit_reg;
        issue_pos_next  = issue_pos_reg;
        s1_valid_next   = 1'b0;
        s2_valid_next   = 1'b0;
        s2_slot_next    = s2_slot_reg;
        res_status_next = res_status_reg;
        res_port_next   = res_port_reg;
        res_slot_next   = res_slot_reg;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (action == ACT_LOOKUP))
                begin
                    res_port_next  = '0;
                    res_slot_next  = '0;
                    key_next       = (arp_opcode == OP_REQUEST) ? sender_addr : target_addr;
                    arrival_next   = arrival_port;
                    limit_next     = count_sat;
                    issue_pos_next = '0;
                    if (!is_arp)
                    begin
                        res_status_next = RES_PASS;
                        state_next      = S_FINISH;
                    end
                    else if ((arp_opcode inside {OP_REQUEST, OP_REPLY})
                             && (count_sat != '0))
                    begin
                        res_status_next = RES_NO_PORT;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        res_status_next = RES_NO_PORT;
                        state_next      = S_FINISH;
                    end
                end
            end

            S_SCAN:
            begin
                if (route_hit)
                begin
                    // First match in scan order wins; in-flight reads are dropped.
                    res_status_next = RES_FOUND;
                    res_port_next   = rd_entry.port;
                    res_slot_next   = s2_slot_reg;
                    state_next      = S_FINISH;
                end
                else if (!issue && !s1_valid_reg && !s2_valid_reg)
                begin
                    res_status_next = RES_NO_PORT;
                    state_next      = S_FINISH;
                end
                else
                begin
                    s1_valid_next = issue;
                    s2_valid_next = s1_valid_reg;
                    s2_slot_next  = order_slot;
                    if (issue)
                    begin
                        issue_pos_next = issue_pos_reg + COUNT_W'(1);
                    end
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_port_next   = out_port_reg;
        out_slot_next   = out_slot_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_port_next   = res_port_reg;
            out_slot_next   = res_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            issue_pos_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_pos_reg <= issue_pos_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                entry_count_reg <= entry_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        arrival_reg    <= arrival_next;
        limit_reg      <= limit_next;
        s2_slot_reg    <= s2_slot_next;
        res_status_reg <= res_status_next;
        res_port_reg   <= res_port_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_port_reg   <= out_port_next;
        out_slot_reg   <= out_slot_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign egress_port  = out_port_reg;
    assign matched_slot = out_slot_reg;

    // Table memories are only read during a scan.
    a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_ctrl.order_rd_en || tbl_ctrl.route_rd_en) |-> (state_reg == S_SCAN))
        else $error("table read outside of a scan");

    // A new result only appears after the sequencer finished a request.
    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result offered without a finished request");

    // No scan stage is left occupied once the block is idle again.
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("scan pipeline busy while idle");

    // The scan never starts positions beyond the captured limit.
    a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_pos_reg <= limit_reg))
        else $error("scan position beyond limit");

    // A found port never equals the port the packet arrived on.
    a_found_port_differs: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && (res_status_reg == RES_FOUND))
        |-> (res_port_reg != arrival_reg))
        else $error("found port equals arrival port");

endmodule
